>>> rtl/wrt_pkg.sv
package wrt_pkg;

    localparam int CAPACITY  = 64;
    localparam int ADDR_BITS = 48;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_ASSIGN = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_ZERO   = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOPAIRS = 2'd3
    } status_t;

    // Classified command handed from the front end to the engine.
    typedef enum logic [1:0] {
        OP_IGNORE = 2'd0,
        OP_SET    = 2'd1,
        OP_ZERO   = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 do_store;
        logic [ADDR_BITS-1:0] slot;
        logic [ADDR_BITS-1:0] val;
        logic [ADDR_BITS-1:0] key;
    } job_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] wa;
        logic [ADDR_BITS-1:0] wv;
        status_t              st;
        logic                 last;
    } res_t;

endpackage

>>> rtl/wrt_ram.sv
module wrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/wrt_front.sv
module wrt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [wrt_pkg::ADDR_BITS-1:0] slot_addr,
    input  logic [wrt_pkg::ADDR_BITS-1:0] target_addr,
    input  logic [wrt_pkg::ADDR_BITS-1:0] current_target,
    output logic                          job_valid,
    input  logic                          job_ready,
    output wrt_pkg::job_t                 job
);

    localparam int PW = $clog2(wrt_pkg::FIFO_DEPTH);

    wrt_pkg::job_t        q_reg [wrt_pkg::FIFO_DEPTH];
    logic [PW-1:0]        wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]          cnt_reg, cnt_next;
    wrt_pkg::job_t        cls;
    logic                 push, pop;

    // Classify the incoming word.
    always_comb
    begin
        cls          = '0;
        cls.op       = wrt_pkg::OP_IGNORE;
        cls.slot     = slot_addr;
        cls.key      = current_target;
        cls.val      = '0;
        cls.do_store = 1'b0;
        case (wrt_pkg::cmd_t'(cmd))
            wrt_pkg::CMD_ASSIGN, wrt_pkg::CMD_CLEAR:
            begin
                if (slot_addr != '0)
                begin
                    cls.op = wrt_pkg::OP_SET;
                    if (cmd == wrt_pkg::CMD_ASSIGN)
                    begin
                        cls.val      = target_addr;
                        cls.do_store = (target_addr != '0);
                    end
                end
            end
            wrt_pkg::CMD_ZERO:
            begin
                if (target_addr != '0)
                begin
                    cls.op  = wrt_pkg::OP_ZERO;
                    cls.key = target_addr;
                end
            end
            default:
            begin
                cls.op = wrt_pkg::OP_IGNORE;
            end
        endcase
    end

    assign in_ready  = (cnt_reg != (PW+1)'(wrt_pkg::FIFO_DEPTH));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;
    assign wp_next   = push ? PW'(wp_reg + 1'b1) : wp_reg;
    assign rp_next   = pop ? PW'(rp_reg + 1'b1) : rp_reg;
    assign cnt_next  = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(wrt_pkg::FIFO_DEPTH))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (PW+1)'(wrt_pkg::FIFO_DEPTH)) |-> !push)
        else $error("push into full queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count mismatch");
`endif

endmodule

>>> rtl/wrt_engine.sv
module wrt_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  wrt_pkg::job_t                 job,
    output logic                          res_valid,
    input  logic                          res_ready,
    output wrt_pkg::res_t                 res
);

    localparam int IW = wrt_pkg::IDX_W;
    localparam int CW = wrt_pkg::CNT_W;
    localparam int AW = wrt_pkg::ADDR_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SREQ  = 8'b0000_0010,
        S_SCMP  = 8'b0000_0100,
        S_SHIFT = 8'b0000_1000,
        S_SWR   = 8'b0001_0000,
        S_EMIT  = 8'b0010_0000,
        S_WAIT  = 8'b0100_0000,
        S_APP   = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    wrt_pkg::job_t   job_reg, job_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   scan_reg, scan_next;   // one above the index being read
    logic [CW-1:0]   sh_reg, sh_next;       // shift write position
    logic            hit_reg, hit_next;     // any match during a zero
    logic            ov_reg, ov_next;
    wrt_pkg::res_t   ores_reg, ores_next;
    logic [AW-1:0]   hit_slot_reg, hit_slot_next;
    logic [AW-1:0]   pend_slot_reg, pend_slot_next;  // zero write not yet sent

    logic            ram_we;
    logic [IW-1:0]   ram_wa, ram_ra;
    logic [AW-1:0]   ws_d, wt_d, rs_q, rt_q;

    wrt_ram #(.WIDTH(AW), .DEPTH(wrt_pkg::CAPACITY)) u_slot_ram (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ws_d),
        .raddr(ram_ra), .rdata(rs_q));
    wrt_ram #(.WIDTH(AW), .DEPTH(wrt_pkg::CAPACITY)) u_tgt_ram (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(wt_d),
        .raddr(ram_ra), .rdata(rt_q));

    logic match;
    assign match = (job_reg.op == wrt_pkg::OP_ZERO) ? (rt_q == job_reg.key)
                 : ((rt_q == job_reg.key) && (rs_q == job_reg.slot));

    // Take a new command only once the result register is free.
    assign job_ready = (state_reg == S_IDLE) && !(ov_reg && !res_ready);
    assign res_valid = ov_reg;
    assign res       = ores_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        sh_next        = sh_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        pend_slot_next = pend_slot_reg;
        ores_next      = ores_reg;
        ov_next        = ov_reg && !res_ready;
        ram_we         = 1'b0;
        ram_wa         = '0;
        ram_ra         = '0;
        ws_d           = job_reg.slot;
        wt_d           = job_reg.val;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid && job_ready)
                begin
                    job_next  = job;
                    scan_next = cnt_reg;
                    hit_next  = 1'b0;
                    if (job.op == wrt_pkg::OP_IGNORE)
                    begin
                        ores_next = '{we: 1'b0, wa: '0, wv: '0,
                                      st: wrt_pkg::ST_NULL, last: 1'b1};
                        state_next = S_WAIT;
                    end
                    else if (job.op == wrt_pkg::OP_SET && job.key == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SREQ;
                    end
                end
            end
            S_SREQ:
            begin
                // Issue read of the next older entry, or finish the scan.
                if (scan_reg == '0)
                begin
                    if (job_reg.op == wrt_pkg::OP_ZERO)
                    begin
                        if (!(ov_reg && !res_ready))
                        begin
                            if (!hit_reg)
                            begin
                                ores_next = '{we: 1'b0, wa: '0, wv: '0,
                                              st: wrt_pkg::ST_NOPAIRS, last: 1'b1};
                            end
                            else
                            begin
                                ores_next = '{we: 1'b1, wa: pend_slot_reg, wv: '0,
                                              st: wrt_pkg::ST_OK, last: 1'b1};
                            end
                            state_next = S_WAIT;
                        end
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    ram_ra     = IW'(scan_reg - 1'b1);
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (match)
                begin
                    hit_slot_next = rs_q;
                    sh_next       = scan_reg - 1'b1;
                    state_next    = S_SHIFT;
                end
                else
                begin
                    scan_next  = scan_reg - 1'b1;
                    state_next = S_SREQ;
                end
            end
            S_SHIFT:
            begin
                // Close the gap: read entry sh+1, or drop the tail.
                if (sh_reg + 1'b1 >= cnt_reg)
                begin
                    cnt_next  = cnt_reg - 1'b1;
                    scan_next = scan_reg - 1'b1;
                    if (job_reg.op == wrt_pkg::OP_ZERO)
                    begin
                        if (ov_reg && !res_ready)
                        begin
                            state_next = S_SHIFT;
                            cnt_next   = cnt_reg;
                            scan_next  = scan_reg;
                        end
                        else
                        begin
                            // Send the write held from the previous match; hold
                            // this one until the scan shows whether more follow.
                            if (hit_reg)
                            begin
                                ores_next = '{we: 1'b1, wa: pend_slot_reg, wv: '0,
                                              st: wrt_pkg::ST_OK, last: 1'b0};
                                ov_next   = 1'b1;
                            end
                            pend_slot_next = hit_slot_reg;
                            hit_next       = 1'b1;
                            state_next     = S_SREQ;
                        end
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    ram_ra     = IW'(sh_reg + 1'b1);
                    state_next = S_SWR;
                end
            end
            S_SWR:
            begin
                ram_we     = 1'b1;
                ram_wa     = IW'(sh_reg);
                ws_d       = rs_q;
                wt_d       = rt_q;
                sh_next    = sh_reg + 1'b1;
                state_next = S_SHIFT;
            end
            S_EMIT:
            begin
                if (job_reg.do_store)
                begin
                    state_next = S_APP;
                end
                else
                begin
                    ores_next = '{we: 1'b1, wa: job_reg.slot, wv: job_reg.val,
                                  st: wrt_pkg::ST_OK, last: 1'b1};
                    state_next = S_WAIT;
                end
            end
            S_APP:
            begin
                if (cnt_reg < CW'(wrt_pkg::CAPACITY))
                begin
                    ram_we    = 1'b1;
                    ram_wa    = IW'(cnt_reg);
                    cnt_next  = cnt_reg + 1'b1;
                    ores_next = '{we: 1'b1, wa: job_reg.slot, wv: job_reg.val,
                                  st: wrt_pkg::ST_OK, last: 1'b1};
                end
                else
                begin
                    ores_next = '{we: 1'b1, wa: job_reg.slot, wv: job_reg.val,
                                  st: wrt_pkg::ST_FULL, last: 1'b1};
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // Present the held result once the register is free.
                if (!(ov_reg && !res_ready))
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        scan_reg      <= scan_next;
        sh_reg        <= sh_next;
        hit_slot_reg  <= hit_slot_next;
        pend_slot_reg <= pend_slot_next;
        ores_reg      <= ores_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(wrt_pkg::CAPACITY))
        else $error("pair count above capacity");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(ores_reg)))
        else $error("result dropped while stalled");
`endif

endmodule

>>> rtl/weak_reference_tracker_unit.sv
// Weak-reference tracker: holds up to CAPACITY (target, slot) pairs.
// Input channel: in_valid/in_ready with cmd, slot_addr, target_addr and
// current_target. Output channel: out_valid/out_ready carrying one
// write request word (write_enable, write_addr, write_value, status, last).
// The front end classifies each word into a two-entry queue; the engine
// scans the pair memory newest to oldest, reading and comparing one entry
// at a time, and closes a gap after a removal by moving each younger pair
// down one place (a read in S_SHIFT, then a write in S_SWR).
// A zero command emits one word per matching pair, newest first, or a
// single no-pairs word if none match; the last flag marks the final word
// of every command.
// Reset clears the pair count, the front queue and the result valid flag;
// memory contents need no clear.
// When out_ready is low the result register holds its word and the engine
// stalls; the front queue keeps taking words until it fills.
module weak_reference_tracker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [wrt_pkg::ADDR_BITS-1:0] slot_addr,
    input  logic [wrt_pkg::ADDR_BITS-1:0] target_addr,
    input  logic [wrt_pkg::ADDR_BITS-1:0] current_target,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          write_enable,
    output logic [wrt_pkg::ADDR_BITS-1:0] write_addr,
    output logic [wrt_pkg::ADDR_BITS-1:0] write_value,
    output logic [1:0]                    status,
    output logic                          last
);

    logic          job_valid, job_ready;
    wrt_pkg::job_t job;
    wrt_pkg::res_t res;

    wrt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .slot_addr(slot_addr), .target_addr(target_addr),
        .current_target(current_target),
        .job_valid(job_valid), .job_ready(job_ready), .job(job));

    wrt_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .res_valid(out_valid), .res_ready(out_ready), .res(res));

    assign write_enable = res.we;
    assign write_addr   = res.wa;
    assign write_value  = res.wv;
    assign status       = res.st;
    assign last         = res.last;

endmodule

>>> test/weak_reference_tracker_unit_test.sv
module weak_reference_tracker_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = wrt_pkg::ADDR_BITS;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4 * wrt_pkg::CAPACITY + 20;
    localparam int RANDOM_WORDS = 150;

    typedef logic [AW-1:0] addr_t;

    // One stimulus word plus an optional typed-in expected result.
    typedef struct {
        wrt_pkg::cmd_t    op;
        addr_t            slot;
        addr_t            tgt;
        addr_t            cur;
        bit               fixed;     // expected result given in the row
        wrt_pkg::status_t fixed_st;
    } stim_row_t;

    typedef struct {
        logic             we;
        addr_t            wa;
        addr_t            wv;
        wrt_pkg::status_t st;
        logic             last;
    } write_req_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] cmd;
    addr_t      slot_addr;
    addr_t      target_addr;
    addr_t      current_target;
    logic       out_valid;
    logic       out_ready;
    logic       write_enable;
    addr_t      write_addr;
    addr_t      write_value;
    logic [1:0] status;
    logic       last;

    weak_reference_tracker_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .slot_addr      (slot_addr),
        .target_addr    (target_addr),
        .current_target (current_target),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .write_enable   (write_enable),
        .write_addr     (write_addr),
        .write_value    (write_value),
        .status         (status),
        .last           (last)
    );

    // Shadow copy of the registration list, oldest pair at index 0.
    addr_t      shadow_slot[$];
    addr_t      shadow_tgt[$];
    write_req_t pending_writes[$];

    int  fail_count;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stim_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drop the newest pair equal to (tgt, slot); a null tgt matches nothing.
    function automatic void unregister_pair(addr_t slot, addr_t tgt);
        if (tgt == '0)
            return;
        for (int i = shadow_slot.size() - 1; i >= 0; i--)
        begin
            if (shadow_tgt[i] == tgt && shadow_slot[i] == slot)
            begin
                shadow_slot.delete(i);
                shadow_tgt.delete(i);
                return;
            end
        end
    endfunction

    function automatic void push_write(logic we, addr_t wa, addr_t wv,
                                       wrt_pkg::status_t st, logic lst);
        write_req_t r;
        r.we = we; r.wa = wa; r.wv = wv; r.st = st; r.last = lst;
        pending_writes.push_back(r);
    endfunction

    // Work out the write requests one command word causes and update the list.
    function automatic void predict_writes(wrt_pkg::cmd_t op, addr_t slot, addr_t tgt,
                                           addr_t cur);
        wrt_pkg::status_t st;
        int               n;
        n = 0;
        st = wrt_pkg::ST_OK;
        if (op == wrt_pkg::CMD_ASSIGN || op == wrt_pkg::CMD_CLEAR)
        begin
            if (slot == '0)
            begin
                push_write(1'b0, '0, '0, wrt_pkg::ST_NULL, 1'b1);
                return;
            end
            unregister_pair(slot, cur);
            if (op == wrt_pkg::CMD_ASSIGN && tgt != '0)
            begin
                if (shadow_slot.size() < wrt_pkg::CAPACITY)
                begin
                    shadow_slot.push_back(slot);
                    shadow_tgt.push_back(tgt);
                end
                else
                    st = wrt_pkg::ST_FULL;
            end
            push_write(1'b1, slot, (op == wrt_pkg::CMD_ASSIGN) ? tgt : '0, st, 1'b1);
            return;
        end
        if (op == wrt_pkg::CMD_RSVD || tgt == '0)
        begin
            push_write(1'b0, '0, '0, wrt_pkg::ST_NULL, 1'b1);
            return;
        end
        for (int i = shadow_slot.size() - 1; i >= 0; i--)
        begin
            if (shadow_tgt[i] == tgt)
            begin
                push_write(1'b1, shadow_slot[i], '0, wrt_pkg::ST_OK, 1'b0);
                shadow_slot.delete(i);
                shadow_tgt.delete(i);
                n++;
            end
        end
        if (n == 0)
            push_write(1'b0, '0, '0, wrt_pkg::ST_NOPAIRS, 1'b1);
        else
            pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    // Idle at random with valid low, then present one word and hold it until accepted.
    task automatic send_word(wrt_pkg::cmd_t op, addr_t slot, addr_t tgt, addr_t cur);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= op;
        slot_addr      <= slot;
        target_addr    <= tgt;
        current_target <= cur;
        do
            @(posedge clk);
        while (!in_ready);
        predict_writes(op, slot, tgt, cur);
    endtask

    // Drop valid and hold the sender until every expected word has come.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall, compare each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        write_req_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected write word: addr %h value %h", write_addr, write_value);
                    fail_count++;
                end
                else
                begin
                    e = pending_writes.pop_front();
                    if (write_enable !== e.we)
                    begin
                        $error("write_enable exp %0d got %0d", e.we, write_enable); fail_count++;
                    end
                    if (write_addr !== e.wa)
                    begin
                        $error("write_addr exp %h got %h", e.wa, write_addr); fail_count++;
                    end
                    if (write_value !== e.wv)
                    begin
                        $error("write_value exp %h got %h", e.wv, write_value); fail_count++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status exp %0d got %0d", e.st, status); fail_count++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, last); fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL weak_reference_tracker_unit");
            $finish;
        end
    end

    // Small address pools keep matches frequent; occasionally use a wide random value.
    function automatic addr_t pick_addr(bit allow_null);
        int r;
        r = $urandom_range(99);
        if (allow_null && r < 5)
            return '0;
        if (r < 85)
            return addr_t'($urandom_range(1, 12)) << 4;
        if (r < 92)
            return '1;
        return addr_t'({$urandom, $urandom});
    endfunction

    stim_row_t directed[] = '{
        '{wrt_pkg::CMD_CLEAR,  48'h0,   48'h0,  48'h0, 1, wrt_pkg::ST_NULL},
        '{wrt_pkg::CMD_ASSIGN, 48'h0,   48'h10, 48'h0, 1, wrt_pkg::ST_NULL},
        '{wrt_pkg::CMD_ZERO,   48'h0,   48'h0,  48'h0, 1, wrt_pkg::ST_NULL},
        '{wrt_pkg::CMD_RSVD,   48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 48'h1,
          1, wrt_pkg::ST_NULL},
        '{wrt_pkg::CMD_ZERO,   48'h0,   48'h20, 48'h0, 1, wrt_pkg::ST_NOPAIRS},
        '{wrt_pkg::CMD_ASSIGN, 48'h100, 48'h20, 48'h0, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ASSIGN, 48'h200, 48'h20, 48'h0, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ASSIGN, 48'h200, 48'h20, 48'h0, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ASSIGN, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 48'h0,
          0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ASSIGN, 48'h100, 48'h30, 48'h20, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ASSIGN, 48'h300, 48'h0,  48'h55, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_CLEAR,  48'h100, 48'h0,  48'h30, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_CLEAR,  48'h400, 48'h0,  48'h77, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ZERO,   48'h0,   48'h20, 48'h0, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ZERO,   48'h0,   48'hFFFFFFFFFFFF, 48'h0, 0, wrt_pkg::ST_OK},
        '{wrt_pkg::CMD_ZERO,   48'h5,   48'h20, 48'h9, 1, wrt_pkg::ST_NOPAIRS}
    };

    initial
    begin
        addr_t s, t, c;
        int    pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = wrt_pkg::CMD_ASSIGN;
        slot_addr = '0;
        target_addr = '0;
        current_target = '0;
        out_ready = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        stim_done = 0;
        send_idle_pct = 33;
        recv_idle_pct = 84;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; check the typed-in result against the predictor's own.
        foreach (directed[i])
        begin
            send_word(directed[i].op, directed[i].slot, directed[i].tgt, directed[i].cur);
            if (directed[i].fixed &&
                pending_writes[pending_writes.size() - 1].st != directed[i].fixed_st)
            begin
                $error("status exp %0d got %0d", directed[i].fixed_st,
                       pending_writes[pending_writes.size() - 1].st);
                fail_count++;
            end
        end

        // Fill to capacity so the full-list path is exercised, then zero it all.
        wait_drained();
        for (int i = 0; i < wrt_pkg::CAPACITY + 2; i++)
            send_word(wrt_pkg::CMD_ASSIGN, addr_t'(i + 1), 48'hABCDEF012345, '0);
        send_word(wrt_pkg::CMD_ZERO, '0, 48'hABCDEF012345, '0);
        wait_drained();

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k == RANDOM_WORDS / 3)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 33;
            end
            else if (k == 2 * RANDOM_WORDS / 3)
            begin
                wait_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            s = pick_addr(1);
            t = pick_addr(1);
            // Mostly use a registered pair as current target so removals happen.
            if (shadow_slot.size() != 0 && $urandom_range(3) != 0)
            begin
                int j;
                j = $urandom_range(shadow_slot.size() - 1);
                s = (pick < 97) ? shadow_slot[j] : s;
                c = shadow_tgt[j];
                if (pick >= 80 && pick < 97)
                    t = shadow_tgt[j];
            end
            else
                c = pick_addr(1);
            if (pick < 55)
                send_word(wrt_pkg::CMD_ASSIGN, s, t, c);
            else if (pick < 75)
                send_word(wrt_pkg::CMD_CLEAR, s, t, c);
            else if (pick < 97)
                send_word(wrt_pkg::CMD_ZERO, s, t, c);
            else
                send_word(wrt_pkg::CMD_RSVD, s, t, c);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_writes.size() == 0)
            $display("PASS weak_reference_tracker_unit");
        else
            $display("FAIL weak_reference_tracker_unit");
        $finish;
    end

endmodule

>>> filelist.f
rtl/wrt_pkg.sv
rtl/wrt_ram.sv
rtl/wrt_front.sv
rtl/wrt_engine.sv
rtl/weak_reference_tracker_unit.sv
test/weak_reference_tracker_unit_test.sv
